>>> sv/array_bst_insert_search_top_macros.svh
// ----------------------------------------------------------------------------
// array_bst_insert_search_top_macros
// Assertion macros for the tree block; NO_ASSERTIONS compiles them away.
// ----------------------------------------------------------------------------
`ifndef ARRAY_BST_INSERT_SEARCH_TOP_MACROS_SVH
`define ARRAY_BST_INSERT_SEARCH_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked property with asynchronous reset gating
`define ABST_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property that also holds during reset
`define ABST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ABST_ASSERT(lbl, clk, rst_n, prop, msg)
`define ABST_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> sv/abst_pkg.sv
// ----------------------------------------------------------------------------
// abst_pkg
// Shared constants, types and helpers of the heap-indexed search tree block.
// ----------------------------------------------------------------------------
package abst_pkg;

	localparam int LEVELS     = 10;
	localparam int KEY_WIDTH  = 32;
	localparam int KEY_IN_W   = 32;
	localparam int KEY_W      = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;
	localparam int SLOTS      = 1 << LEVELS;
	localparam int HT_W       = $clog2(LEVELS + 1);
	localparam int HT_OUT_W   = 4;
	localparam int OUT_DATA_W = 8;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DUP      = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;
	localparam logic [1:0] ST_ZERO     = 2'd3;

	typedef struct packed {
		logic       clear;
		logic       start;
		logic       step;
		logic       write;
		logic       finish;
		logic       found;
		logic [1:0] status;
		logic       push;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic zero_key;
		logic is_search;
		logic empty;
		logic equal;
		logic at_end;
		logic out_free;
	} sts_t;

	// height as shown on the port: low four bits
	function automatic logic [HT_OUT_W-1:0] height_out(input logic [HT_W-1:0] h);
		logic [HT_OUT_W+HT_W-1:0] wide;
		wide = {{HT_OUT_W{1'b0}}, h};
		return wide[HT_OUT_W-1:0];
	endfunction

endpackage

>>> sv/abst_ram.sv
// ----------------------------------------------------------------------------
// abst_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module abst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/abst_dp.sv
// ----------------------------------------------------------------------------
// abst_dp
// Datapath: key and slot registers, compare, height, clear sweep, output stage.
// ----------------------------------------------------------------------------
module abst_dp
	import abst_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic [KEY_IN_W-1:0]   in_key,
	input  logic                  in_action,
	output logic                  ram_we,
	output logic [LEVELS-1:0]     ram_waddr,
	output logic [KEY_W-1:0]      ram_wdata,
	output logic                  ram_re,
	output logic [LEVELS-1:0]     ram_raddr,
	input  logic [KEY_W-1:0]      ram_rdata,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data
);

	logic [KEY_W-1:0]      key_q;
	logic                  search_q;
	logic [LEVELS-1:0]     idx_q;
	logic [HT_W-1:0]       level_q;
	logic [HT_W-1:0]       height_q;
	logic [LEVELS-1:0]     clr_q;
	logic                  res_found_q;
	logic [1:0]            res_status_q;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [KEY_W-1:0]      in_key_w;
	logic                  less;
	logic [LEVELS:0]       next_idx;

	assign in_key_w = in_key[KEY_W-1:0];
	assign less     = $signed(key_q) < $signed(ram_rdata);
	assign next_idx = {idx_q, ~less};

	assign sts.clr_done  = &clr_q;
	assign sts.zero_key  = (in_key_w == '0);
	assign sts.is_search = search_q;
	assign sts.empty     = (ram_rdata == '0);
	assign sts.equal     = (ram_rdata == key_q);
	assign sts.at_end    = next_idx[LEVELS];
	assign sts.out_free  = !out_valid_q || out_ready;

	// root is slot 1; later reads follow the branch picked by the compare
	assign ram_re    = cmd.start || cmd.step;
	assign ram_raddr = cmd.start ? LEVELS'(1) : next_idx[LEVELS-1:0];
	assign ram_we    = cmd.clear || cmd.write;
	assign ram_waddr = cmd.clear ? clr_q : idx_q;
	assign ram_wdata = cmd.clear ? '0 : key_q;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			height_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear && !(&clr_q)) begin
				clr_q <= clr_q + LEVELS'(1);
			end
			if (cmd.write && (level_q > height_q)) begin
				height_q <= level_q;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q    <= in_key_w;
			search_q <= in_action;
			idx_q    <= LEVELS'(1);
			level_q  <= HT_W'(1);
		end else if (cmd.step) begin
			idx_q   <= next_idx[LEVELS-1:0];
			level_q <= level_q + HT_W'(1);
		end
		if (cmd.finish) begin
			res_found_q  <= cmd.found;
			res_status_q <= cmd.status;
		end
		if (cmd.push) begin
			out_data_q <= {1'b0, height_out(height_q), res_status_q, res_found_q};
		end
	end

endmodule

>>> sv/abst_ctrl.sv
// ----------------------------------------------------------------------------
// abst_ctrl
// Controller: clear sweep, tree walk one level per cycle, result hand-off.
// ----------------------------------------------------------------------------
module abst_ctrl
	import abst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					if (sts.zero_key) begin
						cmd.finish = 1'b1;
						cmd.status = ST_ZERO;
						state_d    = S_FIN;
					end else begin
						state_d = S_LOOK;
					end
				end
			end
			S_LOOK: begin
				priority if (sts.empty) begin
					cmd.write  = !sts.is_search;
					cmd.finish = 1'b1;
					cmd.status = ST_OK;
					state_d    = S_FIN;
				end else if (sts.equal) begin
					cmd.finish = 1'b1;
					cmd.found  = 1'b1;
					cmd.status = sts.is_search ? ST_OK : ST_DUP;
					state_d    = S_FIN;
				end else if (sts.at_end) begin
					// walked off the last level without a free slot
					cmd.finish = 1'b1;
					cmd.status = sts.is_search ? ST_OK : ST_OVERFLOW;
					state_d    = S_FIN;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> sv/array_bst_insert_search_top.sv
// ----------------------------------------------------------------------------
// array_bst_insert_search_top
// Binary search tree kept in a heap-indexed key table: insert and search.
// ----------------------------------------------------------------------------
// channel  dir  handshake         payload
// s_*      in   s_tvalid/s_tready tdata[31:0] key, tuser[0] action
// m_*      out  m_tvalid/m_tready tdata[0] found, [2:1] status, [6:3] height
//
// after reset a clearing pass writes every table slot, with s_tready low. an
// item is accepted, then walks one tree level per cycle (at most LEVELS
// levels, one read each through the single table read port), then loads the
// output register; a zero key skips the walk and goes straight to the load.
// one item is in work at a time; a held result stalls only the item behind it.
// ----------------------------------------------------------------------------
`include "array_bst_insert_search_top_macros.svh"

module array_bst_insert_search_top
	import abst_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [KEY_IN_W-1:0]   s_tdata,  // key
	input  logic                  s_tuser,  // action: 0 insert, 1 search
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // found, status[1:0], height[3:0], pad
);

	cmd_t              cmd;
	sts_t              sts;
	logic              ram_we;
	logic [LEVELS-1:0] ram_waddr;
	logic [KEY_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [LEVELS-1:0] ram_raddr;
	logic [KEY_W-1:0]  ram_rdata;

	abst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	abst_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_key    (s_tdata),
		.in_action (s_tuser),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

	abst_ram #(
		.WIDTH (KEY_W),
		.DEPTH (SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// no item is taken before the table is cleared
	`ABST_ASSERT(a_no_accept_in_clear, clk, arst_n, s_tready |-> sts.clr_done, "accept during clear")
	// the walk never passes an empty slot or a matching key
	`ABST_ASSERT(a_step_on_miss, clk, arst_n, cmd.step |-> (!sts.empty && !sts.equal), "bad step")
	// a loaded result shows up on the output next cycle
	`ABST_ASSERT(a_push_valid, clk, arst_n, cmd.push |=> m_tvalid, "result lost")
	// every transfer in issues a start, which begins a walk for a nonzero key
	`ABST_ASSERT(a_accept_start, clk, arst_n, (s_tvalid && s_tready) |-> cmd.start, "no start")

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks insert and search on the heap-indexed tree block. A shadow copy of
// the key table predicts all results but the typed-in probes; each is
// checked field by field; both sides stall at random but in the last phase.
// ----------------------------------------------------------------------------
module tb;
	import abst_pkg::*;

	localparam logic ACT_INSERT  = 1'b0;
	localparam logic ACT_SEARCH  = 1'b1;
	localparam int   PHASE_ITEMS = 510;

	typedef struct packed {
		logic       found;
		logic [1:0] status;
		logic [3:0] height;
	} tree_reply_t;

	typedef struct {
		logic        act;
		logic [31:0] key;
		bit          fixed;  // expectation typed in below, not predicted
		tree_reply_t exp;
	} probe_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [KEY_IN_W-1:0]   s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	// shadow of the key table and height
	logic signed [31:0] shadow_keys [SLOTS];
	int unsigned        shadow_height;
	logic [31:0]        tree_keys [$];
	tree_reply_t        tree_reply_q [$];

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned mismatches;

	array_bst_insert_search_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	initial begin
		#4_800_000;
		$display("FAIL");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// walk the shadow tree the way the block does and update it on insert
	function automatic tree_reply_t tree_walk(input logic act, input logic signed [31:0] k);
		tree_reply_t r;
		int unsigned slot;
		int unsigned lvl;
		bit done;
		r.found = 1'b0;
		r.status = ST_OK;
		if (k == 0) begin
			r.status = ST_ZERO;
		end else begin
			slot = 1;
			lvl = 1;
			done = 1'b0;
			while (!done && slot < SLOTS) begin
				if (shadow_keys[slot] == 0) begin
					if (act == ACT_INSERT) begin
						shadow_keys[slot] = k;
						tree_keys.push_back(k);
						if (lvl > shadow_height)
							shadow_height = lvl;
					end
					done = 1'b1;
				end else if (shadow_keys[slot] == k) begin
					r.found = 1'b1;
					if (act == ACT_INSERT)
						r.status = ST_DUP;
					done = 1'b1;
				end else begin
					slot = (k < shadow_keys[slot]) ? 2 * slot : 2 * slot + 1;
					lvl++;
				end
			end
			if (!done && act == ACT_INSERT)
				r.status = ST_OVERFLOW;
		end
		r.height = shadow_height[3:0];
		return r;
	endfunction

	function automatic probe_row_t probe(input logic act, input logic [31:0] key,
			input bit fixed, input logic f, input logic [1:0] st, input logic [3:0] h);
		probe_row_t p;
		p.act = act;
		p.key = key;
		p.fixed = fixed;
		p.exp.found = f;
		p.exp.status = st;
		p.exp.height = h;
		return p;
	endfunction

	function automatic logic [31:0] pick_key();
		int unsigned roll;
		int unsigned b;
		logic [31:0] k;
		roll = $urandom_range(0, 99);
		b = $urandom_range(0, 31);
		if (roll < 40) begin
			k = $urandom;
		end else if (roll < 65 && tree_keys.size() != 0) begin
			k = tree_keys[$urandom_range(0, tree_keys.size() - 1)];
		end else if (roll < 75 && tree_keys.size() != 0) begin
			// neighbors of stored keys land next to existing nodes
			k = tree_keys[$urandom_range(0, tree_keys.size() - 1)];
			k = $urandom_range(0, 1) ? k + 1 : k - 1;
		end else if (roll < 85) begin
			k = $urandom_range(0, 2000) - 1000;
		end else if (roll < 90) begin
			k = '0;
		end else begin
			case ($urandom_range(0, 5))
				0: k = 32'h7fff_ffff;
				1: k = 32'h8000_0000;
				2: k = 32'h0000_0001;
				3: k = 32'hffff_ffff;
				4: k = 32'h1 << b;
				default: k = ~(32'h1 << b);
			endcase
		end
		return k;
	endfunction

	// present one item, hold it until the transfer, then record what it should give
	task automatic send_item(input logic act, input logic [31:0] k, input bit fixed,
			input tree_reply_t typed_exp);
		tree_reply_t want;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= k;
		s_tuser <= act;
		do
			@(posedge clk);
		while (!s_tready);
		want = tree_walk(act, $signed(k));
		tree_reply_q.push_back(fixed ? typed_exp : want);
	endtask

	// result side: random backpressure and checking
	initial begin
		tree_reply_t want;
		tree_reply_t got;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got.found = m_tdata[0];
				got.status = m_tdata[2:1];
				got.height = m_tdata[6:3];
				if (tree_reply_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h", m_tdata));
				end else begin
					want = tree_reply_q.pop_front();
					if (got.found !== want.found)
						report_mismatch($sformatf("found %b, want %b", got.found, want.found));
					if (got.status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d", got.status,
							want.status));
					if (got.height !== want.height)
						report_mismatch($sformatf("height %0d, want %0d", got.height,
							want.height));
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		probe_row_t probes [$];
		tree_reply_t none;
		logic act;
		none = '0;
		foreach (shadow_keys[i])
			shadow_keys[i] = '0;
		shadow_height = 0;
		mismatches = 0;
		send_idle_pct = 18;
		recv_idle_pct = 82;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= ACT_INSERT;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// a left-leaning chain under 200 reaches the last level, so 191 overflows
		probes = '{
			probe(ACT_SEARCH, 32'd5,         1, 1'b0, ST_OK,       4'd0),
			probe(ACT_INSERT, 32'd0,         1, 1'b0, ST_ZERO,     4'd0),
			probe(ACT_SEARCH, 32'd0,         1, 1'b0, ST_ZERO,     4'd0),
			probe(ACT_INSERT, 32'd100,       1, 1'b0, ST_OK,       4'd1),
			probe(ACT_INSERT, 32'd100,       1, 1'b1, ST_DUP,      4'd1),
			probe(ACT_SEARCH, 32'd100,       1, 1'b1, ST_OK,       4'd1),
			probe(ACT_INSERT, 32'd200,       1, 1'b0, ST_OK,       4'd2),
			probe(ACT_INSERT, 32'd199,       0, 1'b0, ST_OK,       4'd0),
			probe(ACT_INSERT, 32'd198,       0, 1'b0, ST_OK,       4'd0),
			probe(ACT_INSERT, 32'd197,       0, 1'b0, ST_OK,       4'd0),
			probe(ACT_INSERT, 32'd196,       0, 1'b0, ST_OK,       4'd0),
			probe(ACT_INSERT, 32'd195,       0, 1'b0, ST_OK,       4'd0),
			probe(ACT_INSERT, 32'd194,       0, 1'b0, ST_OK,       4'd0),
			probe(ACT_INSERT, 32'd193,       0, 1'b0, ST_OK,       4'd0),
			probe(ACT_INSERT, 32'd192,       0, 1'b0, ST_OK,       4'd0),
			probe(ACT_INSERT, 32'd191,       1, 1'b0, ST_OVERFLOW, 4'd10),
			probe(ACT_SEARCH, 32'd191,       0, 1'b0, ST_OK,       4'd0),
			probe(ACT_SEARCH, 32'd192,       0, 1'b0, ST_OK,       4'd0),
			probe(ACT_INSERT, 32'h8000_0000, 0, 1'b0, ST_OK,       4'd0),
			probe(ACT_INSERT, 32'h7fff_ffff, 0, 1'b0, ST_OK,       4'd0),
			probe(ACT_SEARCH, 32'h8000_0000, 0, 1'b0, ST_OK,       4'd0),
			probe(ACT_SEARCH, 32'h7fff_ffff, 0, 1'b0, ST_OK,       4'd0),
			probe(ACT_SEARCH, 32'hffff_ffff, 0, 1'b0, ST_OK,       4'd0)
		};
		foreach (probes[i])
			send_item(probes[i].act, probes[i].key, probes[i].fixed, probes[i].exp);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 18;
					recv_idle_pct = 82;
				end
				1: begin
					send_idle_pct = 82;
					recv_idle_pct = 18;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				act = $urandom_range(0, 1) ? ACT_SEARCH : ACT_INSERT;
				send_item(act, pick_key(), 0, none);
			end
		end
		s_tvalid <= 1'b0;

		while (tree_reply_q.size() != 0)
			@(posedge clk);
		repeat (LEVELS + 4) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
